### hw/rtl/lbm_pkg.sv
`timescale 1ns / 1ps
package lbm_pkg;

  typedef struct packed {
    logic       req_type;
    logic [6:0] row;
    logic [6:0] col;
    logic [7:0] pixel;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        mask_bit;
    logic [14:0] largest_size;
    logic [13:0] component_count;
    logic        done_res;
  } out_item_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_WIDTH  = 1'b1;

  // coordinate fields are zero-extended to this width before any slicing
  localparam int COORD_XW = 10;

  // neighbor steps: right, down, left, up
  localparam logic signed [1:0] STEP_C [4] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};
  localparam logic signed [1:0] STEP_R [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};

endpackage

### hw/rtl/lbm_ram.sv
`timescale 1ns / 1ps
module lbm_ram #(
  parameter int AW = 14,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/largest_blob_mask.sv
`timescale 1ns / 1ps
// Largest 4-connected blob mask. Loads write one foreground bit per pixel
// (nonzero byte = foreground). Plain loads and reads both register their result
// in the cycle after the transfer edge; a new item is taken only when the block
// is idle again and no output stall holds the last result. The load carrying
// frame_end first stores its pixel, then runs a clearing sweep over every entry
// of the cell memory (2**(2*clog2(MAX_DIM)) entries, one per cycle; a
// read-modify-write that keeps the pixel bit), then a raster scan with a
// stack-based flood fill: each scanned pixel is read, then checked; each popped
// foreground pixel is read from the stack, then its in-frame neighbors are read
// and checked in turn; each component is then closed. The cell memory has one
// read and one write port. One item is handled at a time; the result of a frame
// end gives the largest blob size and the component count, and later reads
// return the mask of that blob until the next frame end. Reads before any frame
// end, and reads outside the frame, return 0.
module largest_blob_mask #(
  parameter int MAX_DIM = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lbm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lbm_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * RW;
  localparam int DW    = RW + 1;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int CW    = AW + 1;
  localparam int MW    = AW + 2;
  localparam logic [CW-1:0] MAX_COMP = CW'(CELLS / 2 + 1);
  localparam logic [AW:0]   DEPTH    = (AW + 1)'(1 << AW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LDWR = 4'd1;
  localparam logic [3:0] S_RDO  = 4'd2;
  localparam logic [3:0] S_CLR  = 4'd3;
  localparam logic [3:0] S_SCRD = 4'd4;
  localparam logic [3:0] S_SCCK = 4'd5;
  localparam logic [3:0] S_POP  = 4'd6;
  localparam logic [3:0] S_POPW = 4'd7;
  localparam logic [3:0] S_NB   = 4'd8;
  localparam logic [3:0] S_NBCK = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]          state_r;
  logic [7:0]          cfg_h_r, cfg_w_r;
  lbm_pkg::in_item_t   req_r;
  logic                inside_r, seen_r;
  logic [AW:0]         clr_r;
  logic [DW-1:0]       sr_r, sc_r, cr_r, cc_r;
  logic [2:0]          k_r;
  logic [AW:0]         sp_r;
  logic [CW-1:0]       sz_r, best_size_r, cnt_r;
  logic [AW-1:0]       best_label_r, nq_r;
  logic                out_valid_r;
  lbm_pkg::out_item_t  out_data_r;

  // clamped frame size
  logic [10:0]   fh_x, fw_x;
  logic [DW-1:0] h, w;
  assign fh_x = {3'b0, cfg_h_r};
  assign fw_x = {3'b0, cfg_w_r};
  assign h = (fh_x > 11'(MAX_DIM)) ? DW'(MAX_DIM) : fh_x[DW-1:0];
  assign w = (fw_x > 11'(MAX_DIM)) ? DW'(MAX_DIM) : fw_x[DW-1:0];

  // incoming coordinates
  logic [lbm_pkg::COORD_XW-1:0] in_r_x, in_c_x, rq_r_x, rq_c_x;
  logic                         in_inside;
  assign in_r_x = lbm_pkg::COORD_XW'(in_data.row);
  assign in_c_x = lbm_pkg::COORD_XW'(in_data.col);
  assign rq_r_x = lbm_pkg::COORD_XW'(req_r.row);
  assign rq_c_x = lbm_pkg::COORD_XW'(req_r.col);
  assign in_inside = (11'(in_data.row) < 11'(h)) && (11'(in_data.col) < 11'(w));

  logic in_xfer;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  // neighbor coordinates
  logic signed [DW:0] nr, nc;
  logic               nb_ok;
  assign nr = $signed({1'b0, cr_r}) + (DW + 1)'(lbm_pkg::STEP_R[k_r[1:0]]);
  assign nc = $signed({1'b0, cc_r}) + (DW + 1)'(lbm_pkg::STEP_C[k_r[1:0]]);
  assign nb_ok = !nr[DW] && !nc[DW] && (nr[DW-1:0] < h) && (nc[DW-1:0] < w);

  // cell memory: {pixel, labeled, label}
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [MW-1:0] m_wdata, m_rdata;
  logic          m_pix, m_vld;
  logic [AW-1:0] m_lab;
  assign m_pix = m_rdata[AW+1];
  assign m_vld = m_rdata[AW];
  assign m_lab = m_rdata[AW-1:0];

  // flood-fill stack
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr, s_wdata, s_rdata;

  logic [AW-1:0] scan_addr;
  logic          seed;
  assign scan_addr = {sr_r[RW-1:0], sc_r[RW-1:0]};
  assign seed = m_pix && !m_vld && (cnt_r < MAX_COMP);

  always_comb begin
    m_we    = 1'b0;
    m_waddr = {rq_r_x[RW-1:0], rq_c_x[RW-1:0]};
    m_wdata = {(req_r.pixel != 8'd0), m_vld, m_lab};
    m_raddr = {in_r_x[RW-1:0], in_c_x[RW-1:0]};
    s_we    = 1'b0;
    s_waddr = sp_r[AW-1:0];
    s_wdata = nq_r;
    s_raddr = sp_r[AW-1:0] - AW'(1);
    unique case (state_r)
      S_LDWR: m_we = inside_r;
      S_CLR: begin
        m_raddr = clr_r[AW-1:0];
        m_we    = (clr_r != '0);
        m_waddr = clr_r[AW-1:0] - AW'(1);
        m_wdata = {m_pix, 1'b0, m_lab};
      end
      S_SCRD: m_raddr = scan_addr;
      S_SCCK: begin
        m_we    = seed;
        m_waddr = scan_addr;
        m_wdata = {1'b1, 1'b1, cnt_r[AW-1:0]};
        // seed goes to the bottom of an empty stack
        s_we    = seed;
        s_waddr = '0;
        s_wdata = scan_addr;
      end
      S_NB: m_raddr = {nr[RW-1:0], nc[RW-1:0]};
      S_NBCK: begin
        m_we    = m_pix && !m_vld;
        m_waddr = nq_r;
        m_wdata = {1'b1, 1'b1, cnt_r[AW-1:0]};
        s_we    = m_pix && !m_vld;
      end
      default: ;
    endcase
  end

  lbm_ram #(.AW(AW), .DW(MW)) u_cells (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  lbm_ram #(.AW(AW), .DW(AW)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // next raster position
  logic [DW:0] sc_inc;
  assign sc_inc = {1'b0, sc_r} + (DW + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_h_r      <= 8'd128;
      cfg_w_r      <= 8'd128;
      seen_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      best_size_r  <= '0;
      best_label_r <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lbm_pkg::CFG_HEIGHT: cfg_h_r <= cfg_wdata;
          default:             cfg_w_r <= cfg_wdata;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            req_r    <= in_data;
            inside_r <= in_inside;
            state_r  <= (in_data.req_type == lbm_pkg::REQ_READ) ? S_RDO : S_LDWR;
          end
        end
        S_LDWR: begin
          if (req_r.frame_end) begin
            clr_r        <= '0;
            seen_r       <= 1'b1;
            best_size_r  <= '0;
            best_label_r <= '0;
            cnt_r        <= '0;
            state_r      <= S_CLR;
          end else begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_RDO: begin
          out_valid_r <= 1'b1;
          out_data_r.mask_bit <= inside_r && seen_r && m_vld && (best_size_r != '0)
                                 && (m_lab == best_label_r);
          out_data_r.largest_size    <= '0;
          out_data_r.component_count <= '0;
          out_data_r.done_res        <= 1'b0;
          state_r     <= S_IDLE;
        end
        S_CLR: begin
          clr_r <= clr_r + (AW + 1)'(1);
          if (clr_r == DEPTH) begin
            sr_r    <= '0;
            sc_r    <= '0;
            state_r <= S_SCRD;
          end
        end
        S_SCRD: begin
          state_r <= ((sr_r >= h) || (w == '0)) ? S_DONE : S_SCCK;
        end
        S_SCCK: begin
          if (seed) begin
            sp_r    <= (AW + 1)'(1);
            sz_r    <= '0;
            state_r <= S_POP;
          end else begin
            if (sc_inc >= {1'b0, w}) begin
              sc_r <= '0;
              sr_r <= sr_r + DW'(1);
            end else begin
              sc_r <= sc_inc[DW-1:0];
            end
            state_r <= S_SCRD;
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            state_r <= S_FIN;
          end else begin
            sp_r    <= sp_r - (AW + 1)'(1);
            sz_r    <= sz_r + CW'(1);
            state_r <= S_POPW;
          end
        end
        S_POPW: begin
          cr_r    <= DW'(s_rdata[AW-1:RW]);
          cc_r    <= DW'(s_rdata[RW-1:0]);
          k_r     <= '0;
          state_r <= S_NB;
        end
        S_NB: begin
          if (k_r == 3'd4) begin
            state_r <= S_POP;
          end else if (nb_ok) begin
            nq_r    <= {nr[RW-1:0], nc[RW-1:0]};
            state_r <= S_NBCK;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_NBCK: begin
          if (m_pix && !m_vld) begin
            sp_r <= sp_r + (AW + 1)'(1);
          end
          k_r     <= k_r + 3'd1;
          state_r <= S_NB;
        end
        S_FIN: begin
          if (sz_r > best_size_r) begin
            best_size_r  <= sz_r;
            best_label_r <= cnt_r[AW-1:0];
          end
          cnt_r <= cnt_r + CW'(1);
          if (sc_inc >= {1'b0, w}) begin
            sc_r <= '0;
            sr_r <= sr_r + DW'(1);
          end else begin
            sc_r <= sc_inc[DW-1:0];
          end
          state_r <= S_SCRD;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_data_r.mask_bit        <= 1'b0;
          out_data_r.largest_size    <= 15'(32'(best_size_r));
          out_data_r.component_count <= 14'(32'(cnt_r));
          out_data_r.done_res        <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
